// ----- rtl/core/vba_pkg.sv -----
// vba_pkg: widths, constants and shared types of the vector bearing block.
// No dependencies; imported by every module under rtl/core.
package vba_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int ANGLE_FRAC = 16;                          // angle LSB = 2^-16 degree
    localparam int TABLE_LEN  = 24;
    localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W      = $clog2(TABLE_LEN);

    // X/Y datapath: coordinate, fraction, one bit for negation, two for growth
    localparam int XY_W  = COORD_WIDTH + ANGLE_FRAC + 3;
    // angle accumulator, signed, holds up to about +/-512 degrees
    localparam int ANG_W = 26;

    localparam int BEAR_W      = 17;
    localparam int S_TDATA_W   = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((BEAR_W + 7) / 8) * 8;

    localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);
    localparam logic [ANG_W-1:0]        ROUND_HALF = ANG_W'(128);
    localparam logic [BEAR_W:0]         FULL_TURN  = (BEAR_W + 1)'(92160);
    localparam logic [BEAR_W-1:0]       BEAR_90    = BEAR_W'(90 * 256);
    localparam logic [BEAR_W-1:0]       BEAR_270   = BEAR_W'(270 * 256);

    typedef logic [IDX_W-1:0] t_stage_idx;

    typedef struct packed {
        logic                    valid;
        logic                    y_zero;
        logic                    x_pos;
        logic                    neg_y;
        logic signed [XY_W-1:0]  cx;
        logic signed [XY_W-1:0]  cy;
        logic signed [ANG_W-1:0] z;
    } t_pipe;

    // atan(2^-i) in degrees, scaled by 2^16, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_deg(input t_stage_idx idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/vba_prep.sv -----
// vba_prep: input stage; folds the vector into the upper half plane.
// Depends on vba_pkg.
module vba_prep
    import vba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    output t_pipe                  o_q
);

    t_pipe r_q;
    t_pipe n_q;

    always_comb begin
        logic signed [XY_W-1:0] x_ext;
        logic signed [XY_W-1:0] y_ext;
        x_ext = XY_W'($signed(i_x));
        y_ext = XY_W'($signed(i_y));
        n_q.valid  = i_valid;
        n_q.y_zero = (i_y == '0);
        n_q.x_pos  = !i_x[COORD_WIDTH-1] && (i_x != '0);
        n_q.neg_y  = i_y[COORD_WIDTH-1];
        // negative y: rotate by 180 degrees, base angle added at the end
        n_q.cx     = (i_y[COORD_WIDTH-1] ? -y_ext : y_ext) <<< ANGLE_FRAC;
        n_q.cy     = (i_y[COORD_WIDTH-1] ? -x_ext : x_ext) <<< ANGLE_FRAC;
        n_q.z      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/vba_cordic_stage.sv -----
// vba_cordic_stage: one registered CORDIC vectoring iteration.
// Depends on vba_pkg (atan_deg table, t_pipe).
module vba_cordic_stage
    import vba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_stage_idx i_idx,
    input  t_pipe      i_d,
    output t_pipe      o_q
);

    t_pipe r_q;
    t_pipe n_q;

    always_comb begin
        logic signed [XY_W-1:0]  cx;
        logic signed [XY_W-1:0]  cy;
        logic signed [XY_W-1:0]  dx;
        logic signed [XY_W-1:0]  dy;
        logic signed [ANG_W-1:0] z;
        logic signed [ANG_W-1:0] step;
        cx   = i_d.cx;
        cy   = i_d.cy;
        z    = i_d.z;
        dx   = cy >>> i_idx;
        dy   = cx >>> i_idx;
        step = atan_deg(i_idx);
        n_q  = i_d;
        if (!cy[XY_W-1]) begin
            n_q.cx = cx + dx;
            n_q.cy = cy - dy;
            n_q.z  = z + step;
        end else begin
            n_q.cx = cx - dx;
            n_q.cy = cy + dy;
            n_q.z  = z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/vba_finish.sv -----
// vba_finish: base angle, wrap to [0,360), round to 1/256 degree, y = 0 cases.
// Two register stages; the second is the output register. Depends on vba_pkg.
module vba_finish
    import vba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_pipe             i_d,
    output logic              o_valid,
    output logic [BEAR_W-1:0] o_bearing
);

    typedef struct packed {
        logic                    valid;
        logic                    y_zero;
        logic                    x_pos;
        logic signed [ANG_W-1:0] total;
    } t_fin;

    t_fin              r_a;
    t_fin              n_a;
    logic              r_valid;
    logic [BEAR_W-1:0] r_bearing;
    logic [BEAR_W-1:0] n_bearing;

    always_comb begin
        logic signed [ANG_W-1:0] sum;
        sum         = (i_d.neg_y ? DEG_180 : ANG_W'(0)) + i_d.z;
        n_a.valid   = i_d.valid;
        n_a.y_zero  = i_d.y_zero;
        n_a.x_pos   = i_d.x_pos;
        n_a.total   = sum[ANG_W-1] ? (sum + DEG_360) : sum;
    end

    always_comb begin
        logic [ANG_W-1:0] rnd;
        logic [BEAR_W:0]  r;
        rnd = r_a.total + ROUND_HALF;
        r   = rnd[ANG_W-1:8];
        if (r >= FULL_TURN) begin
            r = r - FULL_TURN;
        end
        if (r_a.y_zero) begin
            n_bearing = r_a.x_pos ? BEAR_90 : BEAR_270;
        end else begin
            n_bearing = r[BEAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a       <= n_a;
            r_valid   <= r_a.valid;
            r_bearing <= n_bearing;
        end
    end

    assign o_valid   = r_valid;
    assign o_bearing = r_bearing;

endmodule

// ----- rtl/core/vector_bearing_angle.sv -----
// vector_bearing_angle: top level, bearing of a signed vector by pipelined CORDIC.
// Depends on vba_pkg, vba_prep, vba_cordic_stage, vba_finish.
//
//  channel | dir | signals                        | item
//  --------+-----+--------------------------------+---------------------------------
//  s       | in  | i_s_tvalid/o_s_tready/i_s_tdata| [15:0] x_coord, [31:16] y_coord
//  m       | out | o_m_tvalid/i_m_tready/o_m_tdata| [16:0] bearing, 1/256 deg from +y
//
// The pipe has one input fold stage, one register per CORDIC iteration, then
// base/wrap and round/output stages.
// One item enters per cycle when not stalled; the whole pipe advances together on one enable,
// which is low only while the output register holds an item not yet taken.
// Reset (synchronous, active low) clears the valid bits only.
module vector_bearing_angle
    import vba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [15:0] x_coord, [31:16] y_coord
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // [16:0] bearing, rest zero
);

    logic              pipe_en;
    logic              out_valid;
    logic [BEAR_W-1:0] out_bearing;
    t_pipe             stage_q [NUM_STAGES+1];

    // pipe moves whenever the output slot is empty or being drained
    assign pipe_en    = !out_valid || i_m_tready;
    assign o_s_tready = pipe_en;

    vba_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_s_tvalid),
        .i_x     (i_s_tdata[COORD_WIDTH-1:0]),
        .i_y     (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_q     (stage_q[0])
    );

    // one CORDIC iteration per register stage, shift i and atan(2^-i)
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cordic
        vba_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_idx   (IDX_W'(g)),
            .i_d     (stage_q[g]),
            .o_q     (stage_q[g+1])
        );
    end

    vba_finish u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_d       (stage_q[NUM_STAGES]),
        .o_valid   (out_valid),
        .o_bearing (out_bearing)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = M_TDATA_W'(out_bearing);

endmodule
